>>> sv/assert_macros.svh
// Assertion helpers shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/ewet_pkg.sv
package ewet_pkg;

    localparam logic [2:0] REQ_WAKE  = 3'd0;
    localparam logic [2:0] REQ_CONN  = 3'd1;
    localparam logic [2:0] REQ_FAIL  = 3'd2;
    localparam logic [2:0] REQ_OCC   = 3'd3;
    localparam logic [2:0] REQ_FRES  = 3'd4;
    localparam logic [2:0] REQ_SLEEP = 3'd5;
    localparam logic [2:0] REQ_RESET = 3'd6;
    localparam logic [2:0] REQ_MEAS  = 3'd7;

    localparam logic [2:0] REASON_INTERVAL = 3'd0;
    localparam logic [2:0] REASON_CONN     = 3'd1;
    localparam logic [2:0] REASON_FRES     = 3'd2;
    localparam logic [2:0] REASON_RESET    = 3'd3;
    localparam logic [2:0] REASON_LOWPOWER = 3'd4;

    localparam logic [1:0] TREND_POSITIVE = 2'd0;
    localparam logic [1:0] TREND_STABLE   = 2'd1;
    localparam logic [1:0] TREND_NEGATIVE = 2'd2;
    localparam logic [1:0] TREND_CRITICAL = 2'd3;

    localparam logic [1:0] CFG_WINDOW   = 2'd0;
    localparam logic [1:0] CFG_CRITICAL = 2'd1;
    localparam logic [1:0] CFG_NEGATIVE = 2'd2;
    localparam logic [1:0] CFG_POSITIVE = 2'd3;

    localparam logic [32:0] ROUND_MS    = 33'd30000;
    localparam int          DIV_SHIFT   = 5;
    localparam logic [10:0] DIV_ODD     = 11'd1875;
    localparam logic [29:0] DIV_RECIP   = 30'd586406201;
    localparam int          RECIP_SHIFT = 40;

    typedef struct packed {
        logic wake;
        logic conn;
        logic fail;
        logic occ;
        logic fres;
        logic sleep;
        logic rst;
        logic meas;
    } t_cls;

    typedef struct packed {
        t_cls        cls;
        logic [31:0] now_ms;
        logic [31:0] sample_secs;
        logic [31:0] duration_ms;
        logic [9:0]  soc_tenths;
        logic        soc_ok;
        logic [15:0] vcell_mv;
        logic        vcell_ok;
        logic        battery_fault;
        logic        low_power;
    } t_item;

    typedef struct packed {
        logic [2:0]  reason;
        logic [31:0] age_secs;
        logic [10:0] delta_soc;
        logic [16:0] delta_vcell;
        logic [15:0] wakes;
        logic [31:0] conn_ms;
        logic [31:0] awake_ms;
        logic [15:0] occupancy_count;
        logic [15:0] charge_faults;
        logic [15:0] fault_resets;
        logic [15:0] conn_failures;
        logic [1:0]  trend;
    } t_raw;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

>>> sv/ewet_front.sv
`include "assert_macros.svh"

module ewet_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [127:0]         i_s_tdata,
    input  logic [2:0]           i_s_tuser,
    input  logic                 i_take,
    output logic                 o_item_valid,
    output ewet_pkg::t_item      o_item
);

    ewet_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    ewet_pkg::t_item n_item;
    logic            push;
    logic            pop;

    always_comb begin
        n_item = '0;
        n_item.now_ms        = i_s_tdata[31:0];
        n_item.sample_secs   = i_s_tdata[63:32];
        n_item.duration_ms   = i_s_tdata[95:64];
        n_item.soc_tenths    = i_s_tdata[105:96];
        n_item.soc_ok        = i_s_tdata[106];
        n_item.vcell_mv      = i_s_tdata[122:107];
        n_item.vcell_ok      = i_s_tdata[123];
        n_item.battery_fault = i_s_tdata[124];
        n_item.low_power     = i_s_tdata[125];
        case (i_s_tuser)
            ewet_pkg::REQ_WAKE:  n_item.cls.wake  = 1'b1;
            ewet_pkg::REQ_CONN:  n_item.cls.conn  = 1'b1;
            ewet_pkg::REQ_FAIL:  n_item.cls.fail  = 1'b1;
            ewet_pkg::REQ_OCC:   n_item.cls.occ   = 1'b1;
            ewet_pkg::REQ_FRES:  n_item.cls.fres  = 1'b1;
            ewet_pkg::REQ_SLEEP: n_item.cls.sleep = 1'b1;
            ewet_pkg::REQ_RESET: n_item.cls.rst   = 1'b1;
            default:             n_item.cls.meas  = 1'b1;
        endcase
    end

    assign o_s_tready   = (r_count != 2'd2);
    assign push         = i_s_tvalid && o_s_tready;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];
    assign pop          = o_item_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count != 2'd3)
    `ASSERT_ALWAYS(a_ptr_match, i_clk, i_rst_n,
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))

endmodule

>>> sv/ewet_back.sv
`include "assert_macros.svh"

module ewet_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_item_valid,
    input  ewet_pkg::t_item      i_item,
    input  logic                 i_ready,
    output logic                 o_take,
    output logic                 o_raw_valid,
    output ewet_pkg::t_raw       o_raw
);

    logic [31:0]        r_window;
    logic signed [10:0] r_crit;
    logic signed [10:0] r_neg;
    logic signed [10:0] r_pos;

    logic [31:0] r_base_time, n_base_time;
    logic [9:0]  r_base_soc, n_base_soc;
    logic [15:0] r_base_vcell, n_base_vcell;
    logic        r_base_ok, n_base_ok;
    logic [9:0]  r_last_soc, n_last_soc;
    logic        r_last_soc_valid, n_last_soc_valid;
    logic [15:0] r_last_vcell, n_last_vcell;
    logic        r_last_vcell_valid, n_last_vcell_valid;
    logic [15:0] r_wake_count, n_wake_count;
    logic [15:0] r_occ_count, n_occ_count;
    logic [15:0] r_chg_count, n_chg_count;
    logic [15:0] r_fres_count, n_fres_count;
    logic [15:0] r_fail_count, n_fail_count;
    logic [31:0] r_conn_sum, n_conn_sum;
    logic [31:0] r_awake_sum, n_awake_sum;
    logic [31:0] r_awake_start, n_awake_start;
    logic        r_awake_open, n_awake_open;
    logic        r_low_seen, n_low_seen;
    logic        r_fault_seen, n_fault_seen;

    logic               step;
    logic               emit;
    logic               do_rst;
    logic               do_try;
    logic               force_sum;
    logic               chg_after;
    logic [2:0]         reason;
    logic               sv;
    logic [9:0]         soc;
    logic               vv;
    logic [15:0]        vc;
    logic [31:0]        age;
    logic signed [10:0] dsoc;
    ewet_pkg::t_raw     raw;

    assign step   = i_item_valid && i_ready;
    assign o_take = i_ready;

    always_comb begin
        n_base_time        = r_base_time;
        n_base_soc         = r_base_soc;
        n_base_vcell       = r_base_vcell;
        n_base_ok          = r_base_ok;
        n_last_soc         = r_last_soc;
        n_last_soc_valid   = r_last_soc_valid;
        n_last_vcell       = r_last_vcell;
        n_last_vcell_valid = r_last_vcell_valid;
        n_wake_count       = r_wake_count;
        n_occ_count        = r_occ_count;
        n_chg_count        = r_chg_count;
        n_fres_count       = r_fres_count;
        n_fail_count       = r_fail_count;
        n_conn_sum         = r_conn_sum;
        n_awake_sum        = r_awake_sum;
        n_awake_start      = r_awake_start;
        n_awake_open       = r_awake_open;
        n_low_seen         = r_low_seen;
        n_fault_seen       = r_fault_seen;
        emit      = 1'b0;
        do_rst    = 1'b0;
        do_try    = 1'b0;
        force_sum = 1'b0;
        chg_after = 1'b0;
        reason    = ewet_pkg::REASON_INTERVAL;
        sv        = r_last_soc_valid;
        soc       = r_last_soc;
        vv        = r_last_vcell_valid;
        vc        = r_last_vcell;
        age       = '0;
        dsoc      = '0;
        raw       = '0;

        if (step) begin
            if (i_item.cls.wake) begin
                n_wake_count  = ewet_pkg::inc16(r_wake_count);
                n_awake_start = i_item.now_ms;
                n_awake_open  = 1'b1;
            end else if (i_item.cls.conn) begin
                n_conn_sum = ewet_pkg::sat_add32(r_conn_sum, i_item.duration_ms);
                do_try     = 1'b1;
                reason     = ewet_pkg::REASON_CONN;
            end else if (i_item.cls.fail) begin
                n_fail_count = ewet_pkg::inc16(r_fail_count);
            end else if (i_item.cls.occ) begin
                n_occ_count = ewet_pkg::inc16(r_occ_count);
            end else if (i_item.cls.fres) begin
                n_fres_count = ewet_pkg::inc16(r_fres_count);
                do_try       = 1'b1;
                force_sum    = 1'b1;
                reason       = ewet_pkg::REASON_FRES;
            end else if (i_item.cls.sleep || i_item.cls.rst) begin
                if (r_awake_open) begin
                    n_awake_sum  = ewet_pkg::sat_add32(r_awake_sum,
                                                       i_item.now_ms - r_awake_start);
                    n_awake_open = 1'b0;
                end
                if (i_item.cls.rst) begin
                    do_try    = 1'b1;
                    force_sum = 1'b1;
                    reason    = ewet_pkg::REASON_RESET;
                end
            end else begin
                sv = i_item.soc_ok || r_last_soc_valid;
                soc = i_item.soc_ok ? i_item.soc_tenths : r_last_soc;
                vv = i_item.vcell_ok || r_last_vcell_valid;
                vc = i_item.vcell_ok ? i_item.vcell_mv : r_last_vcell;
                if (i_item.soc_ok) begin
                    n_last_soc = i_item.soc_tenths;
                end
                n_last_soc_valid   = sv;
                n_last_vcell       = vv ? vc : 16'd0;
                n_last_vcell_valid = vv;
                if (!r_base_ok) begin
                    do_rst    = 1'b1;
                    chg_after = i_item.battery_fault && !r_fault_seen;
                end else begin
                    if (i_item.battery_fault && !r_fault_seen) begin
                        n_chg_count = ewet_pkg::inc16(r_chg_count);
                    end
                    do_try = 1'b1;
                    if (i_item.low_power && !r_low_seen) begin
                        force_sum = 1'b1;
                        reason    = ewet_pkg::REASON_LOWPOWER;
                    end
                end
                n_low_seen   = i_item.low_power;
                n_fault_seen = i_item.battery_fault;
            end

            if (do_try) begin
                if (!r_base_ok) begin
                    do_rst = 1'b1;
                end else begin
                    age = (i_item.sample_secs > r_base_time) ?
                          i_item.sample_secs - r_base_time : 32'd0;
                    if ((force_sum || (age >= r_window)) && sv && vv) begin
                        emit = 1'b1;
                        do_rst = 1'b1;
                        dsoc = $signed({1'b0, soc}) - $signed({1'b0, r_base_soc});
                        raw.reason          = reason;
                        raw.age_secs        = age;
                        raw.delta_soc       = dsoc;
                        raw.delta_vcell     = {1'b0, vc} - {1'b0, r_base_vcell};
                        raw.wakes           = n_wake_count;
                        raw.conn_ms         = n_conn_sum;
                        raw.awake_ms        = n_awake_open ?
                            ewet_pkg::sat_add32(n_awake_sum, i_item.now_ms - n_awake_start) :
                            n_awake_sum;
                        raw.occupancy_count = n_occ_count;
                        raw.charge_faults   = n_chg_count;
                        raw.fault_resets    = n_fres_count;
                        raw.conn_failures   = n_fail_count;
                        if (dsoc < r_crit) begin
                            raw.trend = ewet_pkg::TREND_CRITICAL;
                        end else if (dsoc < r_neg) begin
                            raw.trend = ewet_pkg::TREND_NEGATIVE;
                        end else if (dsoc > r_pos) begin
                            raw.trend = ewet_pkg::TREND_POSITIVE;
                        end else begin
                            raw.trend = ewet_pkg::TREND_STABLE;
                        end
                    end
                end
            end

            if (do_rst) begin
                n_base_time  = i_item.sample_secs;
                n_base_soc   = sv ? soc : 10'd0;
                n_base_vcell = vv ? vc : 16'd0;
                n_base_ok    = (i_item.sample_secs != 32'd0) && sv && vv;
                n_wake_count = '0;
                n_occ_count  = '0;
                n_chg_count  = chg_after ? 16'd1 : 16'd0;
                n_fres_count = '0;
                n_fail_count = '0;
                n_conn_sum   = '0;
                n_awake_sum  = '0;
                if (n_awake_open) begin
                    n_awake_start = i_item.now_ms;
                end
            end
        end
    end

    assign o_raw_valid = emit;
    assign o_raw       = raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window           <= 32'd86400;
            r_crit             <= -11'sd200;
            r_neg              <= -11'sd50;
            r_pos              <= 11'sd50;
            r_base_time        <= '0;
            r_base_soc         <= '0;
            r_base_vcell       <= '0;
            r_base_ok          <= 1'b0;
            r_last_soc         <= '0;
            r_last_soc_valid   <= 1'b0;
            r_last_vcell       <= '0;
            r_last_vcell_valid <= 1'b0;
            r_wake_count       <= '0;
            r_occ_count        <= '0;
            r_chg_count        <= '0;
            r_fres_count       <= '0;
            r_fail_count       <= '0;
            r_conn_sum         <= '0;
            r_awake_sum        <= '0;
            r_awake_start      <= '0;
            r_awake_open       <= 1'b0;
            r_low_seen         <= 1'b0;
            r_fault_seen       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ewet_pkg::CFG_WINDOW:   r_window <= i_cfg_wdata;
                    ewet_pkg::CFG_CRITICAL: r_crit   <= $signed(i_cfg_wdata[10:0]);
                    ewet_pkg::CFG_NEGATIVE: r_neg    <= $signed(i_cfg_wdata[10:0]);
                    ewet_pkg::CFG_POSITIVE: r_pos    <= $signed(i_cfg_wdata[10:0]);
                    default:                r_window <= r_window;
                endcase
            end
            r_base_time        <= n_base_time;
            r_base_soc         <= n_base_soc;
            r_base_vcell       <= n_base_vcell;
            r_base_ok          <= n_base_ok;
            r_last_soc         <= n_last_soc;
            r_last_soc_valid   <= n_last_soc_valid;
            r_last_vcell       <= n_last_vcell;
            r_last_vcell_valid <= n_last_vcell_valid;
            r_wake_count       <= n_wake_count;
            r_occ_count        <= n_occ_count;
            r_chg_count        <= n_chg_count;
            r_fres_count       <= n_fres_count;
            r_fail_count       <= n_fail_count;
            r_conn_sum         <= n_conn_sum;
            r_awake_sum        <= n_awake_sum;
            r_awake_start      <= n_awake_start;
            r_awake_open       <= n_awake_open;
            r_low_seen         <= n_low_seen;
            r_fault_seen       <= n_fault_seen;
        end
    end

    `ASSERT_ALWAYS(a_base_time_set, i_clk, i_rst_n, !r_base_ok || (r_base_time != 32'd0))
    `ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, emit,
        (r_wake_count == 16'd0) && (r_conn_sum == 32'd0) && (r_awake_sum == 32'd0))

endmodule

>>> sv/ewet_report.sv
module ewet_report (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_raw_valid,
    input  ewet_pkg::t_raw       i_raw,
    output logic                 o_ready,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [175:0]         o_m_tdata,
    output logic [2:0]           o_m_tuser
);

    localparam int YW = 33 - ewet_pkg::DIV_SHIFT;
    localparam int PW = YW + 30;

    logic           en;
    logic           r_s1_valid;
    ewet_pkg::t_raw r_s1;
    logic [YW-1:0]  r_s1_yc;
    logic [YW-1:0]  r_s1_ya;
    logic           r_s2_valid;
    ewet_pkg::t_raw r_s2;
    logic [YW-1:0]  r_s2_yc;
    logic [YW-1:0]  r_s2_ya;
    logic [PW-1:0]  r_s2_pc;
    logic [PW-1:0]  r_s2_pa;
    logic           r_out_valid;
    ewet_pkg::t_raw r_out;
    logic [16:0]    r_out_cmin;
    logic [16:0]    r_out_amin;

    function automatic logic [YW-1:0] scale_ms(input logic [31:0] ms);
        logic [32:0] s;
        s = {1'b0, ms} + ewet_pkg::ROUND_MS;
        return s[32:ewet_pkg::DIV_SHIFT];
    endfunction

    function automatic logic [16:0] fix_quot(input logic [YW-1:0] y, input logic [PW-1:0] p);
        logic [16:0]   q0;
        logic [YW-1:0] rem;
        q0  = p[ewet_pkg::RECIP_SHIFT +: 17];
        rem = y - YW'(q0 * ewet_pkg::DIV_ODD);
        return (rem >= YW'(ewet_pkg::DIV_ODD)) ? q0 + 17'd1 : q0;
    endfunction

    assign en      = !r_out_valid || i_m_tready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1       <= i_raw;
            r_s1_yc    <= scale_ms(i_raw.conn_ms);
            r_s1_ya    <= scale_ms(i_raw.awake_ms);
            r_s2       <= r_s1;
            r_s2_yc    <= r_s1_yc;
            r_s2_ya    <= r_s1_ya;
            r_s2_pc    <= r_s1_yc * ewet_pkg::DIV_RECIP;
            r_s2_pa    <= r_s1_ya * ewet_pkg::DIV_RECIP;
            r_out      <= r_s2;
            r_out_cmin <= fix_quot(r_s2_yc, r_s2_pc);
            r_out_amin <= fix_quot(r_s2_ya, r_s2_pa);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_raw_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.reason;
    assign o_m_tdata  = {r_out.trend, r_out.conn_failures, r_out.fault_resets,
                         r_out.charge_faults, r_out.occupancy_count, r_out_amin,
                         r_out_cmin, r_out.wakes, r_out.delta_vcell, r_out.delta_soc,
                         r_out.age_secs};

endmodule

>>> sv/energy_window_event_tracker.sv
// A summary passes from the input queue through the back end and the report stages s1, s2 and out.
// Throughput: one event per cycle while the output is not stalled; the back end updates its state for each event.
// Minutes rounding runs in a three-stage reciprocal pipeline that stalls with the output.
// Reset is synchronous and active low; it loads the register defaults and clears all
// window state; no clearing pass is needed.
module energy_window_event_tracker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // now_ms, sample_secs, duration_ms, soc_tenths, soc_ok, vcell_mv, vcell_ok,
    // battery_fault, low_power
    input  logic [127:0] s_axis_tdata,
    // req_type
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // age_secs, delta_soc, delta_vcell, wakes, conn_minutes, awake_minutes,
    // occupancy_count, charge_faults, fault_resets, conn_failures, trend
    output logic [175:0] m_axis_tdata,
    // summary_reason
    output logic [2:0]   m_axis_tuser
);

    logic            item_valid;
    ewet_pkg::t_item item;
    logic            take;
    logic            back_ready;
    logic            raw_valid;
    ewet_pkg::t_raw  raw;

    ewet_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_take       (take),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    ewet_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_ready      (back_ready),
        .o_take       (take),
        .o_raw_valid  (raw_valid),
        .o_raw        (raw)
    );

    ewet_report u_report (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_raw_valid (raw_valid),
        .i_raw       (raw),
        .o_ready     (back_ready),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule
